// ===== rtl/ppl_pkg.sv =====
`default_nettype none

package ppl_pkg;

   // Parameter phases
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_ID    = 2'd1;
   localparam logic [1:0] PH_KEY   = 2'd2;
   localparam logic [1:0] PH_VALUE = 2'd3;

   // Result kinds
   localparam logic [2:0] K_ID_DIGIT  = 3'd0;
   localparam logic [2:0] K_KEY_BYTE  = 3'd1;
   localparam logic [2:0] K_VAL_START = 3'd2;
   localparam logic [2:0] K_VAL_BYTE  = 3'd3;
   localparam logic [2:0] K_PARAM_END = 3'd4;
   localparam logic [2:0] K_LIST_END  = 3'd5;
   localparam logic [2:0] K_REJECTED  = 3'd6;

   // ID limits
   localparam logic [19:0] ID_MAX        = 20'd999999;
   localparam logic [2:0]  ID_MAX_DIGITS = 3'd6;

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   // Classified word passed from front to back
   typedef struct packed {
      logic       last;
      logic [7:0] raw;
      logic [7:0] upper;
      logic       digit;
      logic       nz_digit;
      logic       alpha;
      logic       comma;
      logic       equals;
      logic       forbidden;
   } ppl_item_type;

endpackage

`default_nettype wire

// ===== rtl/packet_param_list_parser_top.sv =====
`default_nettype none

// Streaming parser for a packet's comma-separated parameter list. Each input word
// carries one list byte in req_tdata; a word with req_tlast high closes the list
// (its byte is ignored). Every input word yields exactly one result word whose kind
// sits in rsp_tuser: ID digit, key byte (uppercased), value start, value byte,
// parameter end, list end (with validity and last packet ID) or rejected. The front
// classifies bytes and queues them; the back runs the parse state machine, which
// takes one word per clock while the result side does not stall. Each input word is
// written into the queue when accepted, and the back registers its result in the
// output register once the words ahead of it have been taken; the queue absorbs
// result-side stalls.
module packet_param_list_parser_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   input  wire logic        req_tlast,    // action: end of list
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [7:0] out_byte, [8] naked, [9] error,
                                          // [29:10] packet_id, [30] list_valid
   output logic [2:0]       rsp_tuser     // [2:0] kind
);
   import ppl_pkg::*;

   localparam int ITEM_W = $bits(ppl_item_type);

   ppl_item_type     front_item;
   ppl_item_type     back_item;
   logic [ITEM_W-1:0] back_bits;
   logic             push;
   logic             queue_full;
   logic             pop;
   logic             back_valid;

   ppl_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .item       (front_item)
   );

   ppl_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (back_bits),
      .not_empty (back_valid)
   );

   assign back_item = ppl_item_type'(back_bits);

   ppl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item       (back_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/ppl_front.sv =====
`default_nettype none

module ppl_front (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,    // [7:0] in_byte
   input  wire logic                 req_tlast,    // end of list
   input  wire logic                 queue_full,
   output logic                      push,
   output ppl_pkg::ppl_item_type     item
);
   import ppl_pkg::*;

   logic is_upper;
   logic is_lower;
   logic is_digit;

   // Classify the incoming byte
   always_comb begin
      is_upper = (req_tdata >= CH_UA) && (req_tdata <= CH_UZ);
      is_lower = (req_tdata >= CH_LA) && (req_tdata <= CH_LZ);
      is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);

      item.last      = req_tlast;
      item.raw       = req_tdata;
      item.upper     = is_lower ? (req_tdata - 8'd32) : req_tdata;
      item.digit     = is_digit;
      item.nz_digit  = is_digit && (req_tdata != CH_ZERO);
      item.alpha     = is_upper || is_lower;
      item.comma     = (req_tdata == CH_COMMA);
      item.equals    = (req_tdata == CH_EQ);
      item.forbidden = (req_tdata == CH_EQ) || (req_tdata == CH_SPACE) ||
                       (req_tdata == CH_COLON) || (req_tdata == CH_LT) ||
                       (req_tdata == CH_NUL);
   end

   // Accept a word whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

`default_nettype wire

// ===== rtl/ppl_queue.sv =====
`default_nettype none

module ppl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not raise occupancy");

endmodule

`default_nettype wire

// ===== rtl/ppl_back.sv =====
`default_nettype none

module ppl_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire ppl_pkg::ppl_item_type item,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,  // [7:0] out_byte, [8] naked, [9] error,
                                                  // [29:10] packet_id, [30] list_valid
   output logic [2:0]                 rsp_tuser   // [2:0] kind
);
   import ppl_pkg::*;

   logic [1:0]  phase_ff,  phase_in;
   logic        err_ff,    err_in;
   logic [19:0] acc_ff,    acc_in;
   logic [2:0]  cnt_ff,    cnt_in;
   logic [19:0] latest_ff, latest_in;

   logic        out_valid_ff;
   logic [2:0]  out_kind_ff,  out_kind;
   logic [7:0]  out_byte_ff,  out_byte;
   logic        out_naked_ff, out_naked;
   logic        out_err_ff,   out_err;
   logic [19:0] out_pid_ff,   out_pid;
   logic        out_lv_ff,    out_lv;
   logic        bad;
   logic [19:0] acc_x10;

   // Take the next word when the output register is free or draining
   assign pop     = item_valid && (!out_valid_ff || rsp_tready);
   assign acc_x10 = {acc_ff[16:0], 3'b000} + {acc_ff[18:0], 1'b0};

   // Parse one word
   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      latest_in = latest_ff;
      out_kind  = K_REJECTED;
      out_byte  = item.raw;
      out_naked = 1'b0;
      out_pid   = '0;
      out_lv    = 1'b0;
      out_err   = err_ff;
      bad       = 1'b0;

      if (item.last) begin
         out_kind  = K_LIST_END;
         out_byte  = '0;
         out_pid   = (!err_ff && (phase_ff == PH_ID)) ? acc_ff : latest_ff;
         out_lv    = !err_ff;
         phase_in  = PH_START;
         err_in    = 1'b0;
         acc_in    = '0;
         cnt_in    = '0;
         latest_in = '0;
      end else if (err_ff) begin
         bad = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (item.nz_digit) begin
                  acc_in   = {16'd0, item.raw[3:0]};
                  cnt_in   = 3'd1;
                  phase_in = PH_ID;
                  out_kind = K_ID_DIGIT;
               end else if (item.alpha) begin
                  phase_in = PH_KEY;
                  out_kind = K_KEY_BYTE;
                  out_byte = item.upper;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_ID: begin
               if (item.digit && (cnt_ff < ID_MAX_DIGITS)) begin
                  acc_in   = acc_x10 + {16'd0, item.raw[3:0]};
                  cnt_in   = cnt_ff + 1'b1;
                  out_kind = K_ID_DIGIT;
               end else if (item.comma) begin
                  latest_in = acc_ff;
                  acc_in    = '0;
                  cnt_in    = '0;
                  phase_in  = PH_START;
                  out_kind  = K_PARAM_END;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_KEY: begin
               if (item.alpha || item.digit) begin
                  out_kind = K_KEY_BYTE;
                  out_byte = item.upper;
               end else if (item.equals) begin
                  phase_in = PH_VALUE;
                  out_kind = K_VAL_START;
               end else if (item.comma) begin
                  phase_in  = PH_START;
                  out_kind  = K_PARAM_END;
                  out_naked = 1'b1;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_VALUE: begin
               if (item.comma) begin
                  phase_in = PH_START;
                  out_kind = K_PARAM_END;
               end else if (item.forbidden) begin
                  bad = 1'b1;
               end else begin
                  out_kind = K_VAL_BYTE;
               end
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            err_in    = 1'b1;
            out_kind  = K_REJECTED;
            out_byte  = item.raw;
            out_naked = 1'b0;
         end
         out_err = err_in;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         err_ff    <= 1'b0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         latest_ff <= '0;
      end else if (pop) begin
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         latest_ff <= latest_in;
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_kind_ff  <= out_kind;
         out_byte_ff  <= out_byte;
         out_naked_ff <= out_naked;
         out_err_ff   <= out_err;
         out_pid_ff   <= out_pid;
         out_lv_ff    <= out_lv;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_lv_ff, out_pid_ff, out_err_ff, out_naked_ff, out_byte_ff};

   a_list_end_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == K_LIST_END)) |-> (out_lv_ff != out_err_ff))
      else $error("list end validity disagrees with error");

   a_other_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff != K_LIST_END)) |-> ((out_pid_ff == '0) && !out_lv_ff))
      else $error("packet id or validity on a non-end word");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && item.last) |=> ((phase_ff == PH_START) && !err_ff && (latest_ff == '0)))
      else $error("state not cleared after list end");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      (acc_ff <= ID_MAX) && (latest_ff <= ID_MAX) && (cnt_ff <= ID_MAX_DIGITS))
      else $error("packet id out of range");

endmodule

`default_nettype wire

// ===== dv/packet_param_list_parser_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the parameter list parser, predicts one result word per
// accepted input word and compares every accepted result against the oldest prediction.
module packet_param_list_parser_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   output int               mismatch_count,
   output int               waiting_count
);
   import ppl_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic        naked;
      logic        error;
      logic [19:0] packet_id;
      logic        list_valid;
   } parse_event_type;

   // Shadow copy of the parse state
   logic [1:0]  phase;
   logic        err_seen;
   logic [19:0] id_acc;
   logic [2:0]  id_digits;
   logic [19:0] last_id;

   parse_event_type event_q[$];

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return c >= CH_LA && c <= CH_LZ;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UA && c <= CH_UZ) || is_lower(c);
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return is_lower(c) ? c - (CH_LA - CH_UA) : c;
   endfunction

   function automatic void clear_parse_state();
      phase     = PH_START;
      err_seen  = 1'b0;
      id_acc    = '0;
      id_digits = '0;
      last_id   = '0;
   endfunction

   // Advance the shadow state by one word and return the event it should produce
   function automatic parse_event_type parse_word(input logic last, input logic [7:0] c);
      parse_event_type ev;
      logic            bad;
      ev          = '0;
      ev.kind     = K_REJECTED;
      ev.out_byte = c;
      bad         = 1'b0;

      // End of list: commit a pending ID, report, then start over
      if (last) begin
         if (!err_seen && phase == PH_ID) last_id = id_acc;
         ev.kind       = K_LIST_END;
         ev.out_byte   = '0;
         ev.error      = err_seen;
         ev.packet_id  = last_id;
         ev.list_valid = !err_seen;
         clear_parse_state();
         return ev;
      end

      if (err_seen) begin
         bad = 1'b1;
      end else begin
         case (phase)
            PH_START: begin
               if (is_digit(c) && c != CH_ZERO) begin
                  id_acc    = 20'(c - CH_ZERO);
                  id_digits = 3'd1;
                  phase     = PH_ID;
                  ev.kind   = K_ID_DIGIT;
               end else if (is_letter(c)) begin
                  phase       = PH_KEY;
                  ev.kind     = K_KEY_BYTE;
                  ev.out_byte = upcase(c);
               end else begin
                  bad = 1'b1;
               end
            end
            PH_ID: begin
               if (is_digit(c) && id_digits < ID_MAX_DIGITS) begin
                  id_acc    = id_acc * 20'd10 + 20'(c - CH_ZERO);
                  id_digits = id_digits + 3'd1;
                  ev.kind   = K_ID_DIGIT;
               end else if (c == CH_COMMA) begin
                  last_id   = id_acc;
                  id_acc    = '0;
                  id_digits = '0;
                  phase     = PH_START;
                  ev.kind   = K_PARAM_END;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_KEY: begin
               if (is_digit(c) || is_letter(c)) begin
                  ev.kind     = K_KEY_BYTE;
                  ev.out_byte = upcase(c);
               end else if (c == CH_EQ) begin
                  phase   = PH_VALUE;
                  ev.kind = K_VAL_START;
               end else if (c == CH_COMMA) begin
                  phase    = PH_START;
                  ev.kind  = K_PARAM_END;
                  ev.naked = 1'b1;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_VALUE: begin
               if (c == CH_COMMA) begin
                  phase   = PH_START;
                  ev.kind = K_PARAM_END;
               end else if (c == CH_EQ || c == CH_SPACE || c == CH_COLON ||
                            c == CH_LT || c == CH_NUL) begin
                  bad = 1'b1;
               end else begin
                  ev.kind = K_VAL_BYTE;
               end
            end
         endcase
      end

      // Rejected byte: the error sticks until the end of the list
      if (bad) begin
         err_seen    = 1'b1;
         ev.kind     = K_REJECTED;
         ev.out_byte = c;
         ev.naked    = 1'b0;
      end
      ev.error = err_seen;
      return ev;
   endfunction

   // Predict on accepted input words, compare on accepted result words
   always @(posedge clock) begin
      parse_event_type got;
      parse_event_type want;
      if (reset) begin
         clear_parse_state();
         event_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) event_q.push_back(parse_word(req_tlast, req_tdata));

         if (rsp_tvalid && rsp_tready) begin
            got.kind       = rsp_tuser;
            got.out_byte   = rsp_tdata[7:0];
            got.naked      = rsp_tdata[8];
            got.error      = rsp_tdata[9];
            got.packet_id  = rsp_tdata[29:10];
            got.list_valid = rsp_tdata[30];
            if (event_q.size() == 0) begin
               $error("unexpected result word: kind %0d, tdata %h", rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = event_q.pop_front();
               if (got.kind != want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                  mismatch_count++;
               end
               if (got.out_byte != want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                  mismatch_count++;
               end
               if (got.naked != want.naked) begin
                  $error("naked: expected %0d, actual %0d", want.naked, got.naked);
                  mismatch_count++;
               end
               if (got.error != want.error) begin
                  $error("error: expected %0d, actual %0d", want.error, got.error);
                  mismatch_count++;
               end
               if (got.packet_id != want.packet_id) begin
                  $error("packet_id: expected %0d, actual %0d", want.packet_id,
                         got.packet_id);
                  mismatch_count++;
               end
               if (got.list_valid != want.list_valid) begin
                  $error("list_valid: expected %0d, actual %0d", want.list_valid,
                         got.list_valid);
                  mismatch_count++;
               end
            end
         end
      end
      waiting_count = event_q.size();
   end

endmodule

// ===== dv/packet_param_list_parser_top_tb.sv =====
`timescale 1ns / 100ps

module packet_param_list_parser_top_tb;
   import ppl_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int SEND_IDLE  [4]  = '{0, 86, 0, 31};
   localparam int RECV_STALL [4]  = '{0, 0, 86, 31};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tlast  = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int mismatches;
   int waiting;

   packet_param_list_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   packet_param_list_parser_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatches),
      .waiting_count  (waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one word, with random gaps ahead of it, and hold it until accepted
   task automatic send_word(input logic last, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tlast  = last;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit close);
      foreach (s[i]) send_word(1'b0, s[i]);
      if (close) send_word(1'b1, 8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return (r < 26) ? CH_UA + 8'(r) : CH_LA + 8'(r - 26);
   endfunction

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(61);
      if (r < 10) return CH_ZERO + 8'(r);
      return rand_letter();
   endfunction

   function automatic logic [7:0] rand_value_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(255));
      while (v == CH_EQ || v == CH_SPACE || v == CH_COLON || v == CH_LT ||
             v == CH_NUL || v == CH_COMMA);
      return v;
   endfunction

   // Build one list: mostly well formed with random content, some noise and damage
   task automatic build_list(ref logic [7:0] q[$]);
      int n_params;
      int len;
      q.delete();
      if ($urandom_range(99) < 10) begin
         len = $urandom_range(6);
         repeat (len) q.push_back(8'($urandom_range(255)));
         return;
      end
      n_params = $urandom_range(1, 4);
      for (int i = 0; i < n_params; i++) begin
         if (i > 0) q.push_back(CH_COMMA);
         if ($urandom_range(99) < 40) begin
            len = ($urandom_range(99) < 5) ? 7 : $urandom_range(1, 6);
            q.push_back(($urandom_range(99) < 3) ? CH_ZERO
                                                 : CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (len - 1) q.push_back(CH_ZERO + 8'($urandom_range(9)));
         end else begin
            q.push_back(rand_letter());
            repeat ($urandom_range(3)) q.push_back(rand_alnum());
            if ($urandom_range(99) < 60) begin
               q.push_back(CH_EQ);
               repeat ($urandom_range(4)) q.push_back(rand_value_byte());
            end
         end
      end
      if ($urandom_range(99) < 30) q.push_back(CH_COMMA);
      if ($urandom_range(99) < 12) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(99) < 5) q.insert($urandom_range(q.size()), CH_COMMA);
   endtask

   initial begin
      logic [7:0] list_q[$];
      int         sent;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lists, no idling
      send_text("", 1'b1);                       // empty list
      send_text(",", 1'b0);                      // leading comma, then a byte after error
      send_word(1'b0, 8'hFF);
      send_word(1'b1, 8'hFF);
      send_text("0", 1'b1);                      // leading zero
      send_text("999999,a,", 1'b1);              // largest ID, naked key, trailing comma
      send_text("1234567", 1'b1);                // seventh ID digit
      send_text("7,k=", 1'b0);                   // ID kept across a bad value byte
      send_word(1'b0, 8'hFF);
      send_word(1'b0, CH_NUL);
      send_word(1'b1, 8'h00);
      send_text("b=,,", 1'b1);                   // empty value, then two commas in a row

      // Random lists over the idling phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            build_list(list_q);
            foreach (list_q[i]) send_word(1'b0, list_q[i]);
            send_word(1'b1, 8'($urandom_range(255)));
            sent += list_q.size() + 1;
         end
      end
      req_tvalid = 1'b0;

      // Drain outstanding results, then let the pipeline settle
      while (waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && waiting == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== packet_param_list_parser_top.f =====
rtl/ppl_pkg.sv
rtl/ppl_front.sv
rtl/ppl_queue.sv
rtl/ppl_back.sv
rtl/packet_param_list_parser_top.sv
dv/packet_param_list_parser_checker.sv
dv/packet_param_list_parser_top_tb.sv
